// ----- hdl/lif_pkg.sv -----
// Shared types, constants and register codes of the leaky integrate-and-fire neuron.
package lif_pkg;

  localparam int unsigned VOLT_W  = 24;
  localparam int unsigned CUR_W   = 23;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned FACT_W  = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DRIVE_W = 48;
  localparam int unsigned LEAK_W  = 42;
  localparam int unsigned ACC_W   = 49;
  localparam int unsigned DPROD_W = CUR_W + FACT_W;

  localparam logic [FACT_W-1:0]        ONE_Q16 = 17'd65536;
  localparam logic signed [VOLT_W-1:0] V_MAX   = 24'sh7FFFFF;
  localparam logic signed [VOLT_W-1:0] V_MIN   = 24'sh800000;
  localparam logic [CUR_W-1:0]         I_MAX   = 23'h7FFFFF;

  localparam logic [FACT_W-1:0]        RST_MEMBRANE_RATE   = 17'd6554;
  localparam logic [CUR_W-1:0]         RST_DRIVE_GAIN      = 23'd6554;
  localparam logic signed [VOLT_W-1:0] RST_SPIKE_THRESHOLD = 24'sd65536;
  localparam logic signed [VOLT_W-1:0] RST_RESET_VOLTAGE   = 24'sd0;
  localparam logic [FACT_W-1:0]        RST_CURRENT_DECAY   = 17'd59299;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEMBRANE_RATE   = 3'd0,
    CFG_DRIVE_GAIN      = 3'd1,
    CFG_SPIKE_THRESHOLD = 3'd2,
    CFG_RESET_VOLTAGE   = 3'd3,
    CFG_CURRENT_DECAY   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [FACT_W-1:0]        membrane_rate;
    logic [CUR_W-1:0]         drive_gain;
    logic signed [VOLT_W-1:0] spike_threshold;
    logic signed [VOLT_W-1:0] reset_voltage;
    logic [FACT_W-1:0]        current_decay;
  } cfg_t;

endpackage

// ----- hdl/lif_if.sv -----
// Request channel interfaces for the neuron input, result and configuration ports.
interface lif_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [lif_pkg::VOLT_W-1:0] input_sum;

  modport source (output valid, output input_sum, input ready);
  modport sink   (input valid, input input_sum, output ready);
endinterface

interface lif_out_if;
  logic                              valid;
  logic                              ready;
  logic                              spiked;
  logic [lif_pkg::CUR_W-1:0]         output_current;
  logic signed [lif_pkg::VOLT_W-1:0] membrane_level;

  modport source (output valid, output spiked, output output_current,
                  output membrane_level, input ready);
  modport sink   (input valid, input spiked, input output_current,
                  input membrane_level, output ready);
endinterface

interface lif_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lif_pkg::CFG_IDX_W-1:0]       index;
  logic [lif_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/lif_cfg_regs.sv -----
// Configuration register file of the neuron with clamping of the unity factors.
module lif_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  lif_cfg_if.sink         cfg_ch,
  output lif_pkg::cfg_t   cfg
);
  import lif_pkg::*;

  logic [FACT_W-1:0]        membrane_rate_r;
  logic [CUR_W-1:0]         drive_gain_r;
  logic signed [VOLT_W-1:0] spike_threshold_r;
  logic signed [VOLT_W-1:0] reset_voltage_r;
  logic [FACT_W-1:0]        current_decay_r;
  logic                     wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      membrane_rate_r   <= RST_MEMBRANE_RATE;
      drive_gain_r      <= RST_DRIVE_GAIN;
      spike_threshold_r <= RST_SPIKE_THRESHOLD;
      reset_voltage_r   <= RST_RESET_VOLTAGE;
      current_decay_r   <= RST_CURRENT_DECAY;
    end else if (wr_en) begin
      unique case (cfg_ch.index)
        CFG_MEMBRANE_RATE:   membrane_rate_r   <= cfg_ch.data[FACT_W-1:0];
        CFG_DRIVE_GAIN:      drive_gain_r      <= cfg_ch.data[CUR_W-1:0];
        CFG_SPIKE_THRESHOLD: spike_threshold_r <= $signed(cfg_ch.data[VOLT_W-1:0]);
        CFG_RESET_VOLTAGE:   reset_voltage_r   <= $signed(cfg_ch.data[VOLT_W-1:0]);
        CFG_CURRENT_DECAY:   current_decay_r   <= cfg_ch.data[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // The rate and decay factors above one are treated as exactly one.
  always_comb begin
    cfg.membrane_rate   = (membrane_rate_r > ONE_Q16) ? ONE_Q16 : membrane_rate_r;
    cfg.drive_gain      = drive_gain_r;
    cfg.spike_threshold = spike_threshold_r;
    cfg.reset_voltage   = reset_voltage_r;
    cfg.current_decay   = (current_decay_r > ONE_Q16) ? ONE_Q16 : current_decay_r;
  end

endmodule

// ----- hdl/lif_neuron_step.sv -----
// Leaky integrate-and-fire neuron advanced one time step per input request.
// Each input request carries one tick's summed input voltage in signed Q8.16 and
// produces exactly one result request holding the spike flag, the decayed output
// current and the new membrane voltage. The block is a two-stage pipeline: the
// first stage registers the input times the drive gain, the second applies the
// membrane leak, threshold test and current decay to the neuron state and loads
// the result register. A new request is accepted every cycle while results are
// taken; a request leaves the drive register once the result register is free.
// Configuration writes are accepted every cycle and must only be issued while
// the neuron idles.
module lif_neuron_step (
  input  logic       clk,
  input  logic       rst_n,
  lif_in_if.sink     in_ch,
  lif_out_if.source  out_ch,
  lif_cfg_if.sink    cfg_ch
);
  import lif_pkg::*;

  cfg_t cfg;

  logic                      a_valid_r;
  logic signed [DRIVE_W-1:0] a_drive_r;
  logic signed [DRIVE_W-1:0] a_drive_nxt;

  logic signed [VOLT_W-1:0]  membrane_r;
  logic signed [VOLT_W-1:0]  membrane_nxt;
  logic [CUR_W-1:0]          current_r;
  logic [CUR_W-1:0]          current_nxt;

  logic                      out_valid_r;
  logic                      spiked_r;

  logic                      out_free;
  logic                      advance_b;

  logic [FACT_W-1:0]         leak_fac;
  logic signed [LEAK_W-1:0]  leak_prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [VOLT_W-1:0]  v_sat;
  logic                      fired;
  logic [CUR_W:0]            cur_inc;
  logic [CUR_W-1:0]          cur_spk;
  logic [DPROD_W-1:0]        prod_keep;
  logic [DPROD_W-1:0]        prod_spk;

  lif_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign out_free     = !out_valid_r || out_ch.ready;
  assign advance_b    = a_valid_r && out_free;
  assign in_ch.ready  = !a_valid_r || advance_b;
  assign out_ch.valid = out_valid_r;
  assign out_ch.spiked = spiked_r;
  assign out_ch.output_current = current_r;
  assign out_ch.membrane_level = membrane_r;

  assign a_drive_nxt = $signed({1'b0, cfg.drive_gain}) * in_ch.input_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_drive_r <= a_drive_nxt;
    end
  end

  // Membrane update with floor division by one in Q16 and saturation.
  always_comb begin
    leak_fac  = ONE_Q16 - cfg.membrane_rate;
    leak_prod = membrane_r * $signed({1'b0, leak_fac});
    acc = {{(ACC_W-LEAK_W){leak_prod[LEAK_W-1]}}, leak_prod}
        + {{(ACC_W-DRIVE_W){a_drive_r[DRIVE_W-1]}}, a_drive_r};
    if (acc[ACC_W-1:FRAC_W+VOLT_W-1] == '0 || acc[ACC_W-1:FRAC_W+VOLT_W-1] == '1) begin
      v_sat = acc[FRAC_W+VOLT_W-1:FRAC_W];
    end else if (acc[ACC_W-1]) begin
      v_sat = V_MIN;
    end else begin
      v_sat = V_MAX;
    end
    fired        = v_sat > cfg.spike_threshold;
    membrane_nxt = fired ? cfg.reset_voltage : v_sat;
  end

  // Both decay products are formed in parallel and the spike selects one.
  always_comb begin
    cur_inc   = {1'b0, current_r} + (CUR_W+1)'(ONE_Q16);
    cur_spk   = cur_inc[CUR_W] ? I_MAX : cur_inc[CUR_W-1:0];
    prod_keep = current_r * cfg.current_decay;
    prod_spk  = cur_spk * cfg.current_decay;
    current_nxt = fired ? prod_spk[FRAC_W+CUR_W-1:FRAC_W]
                        : prod_keep[FRAC_W+CUR_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      membrane_r  <= '0;
      current_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (advance_b) begin
      membrane_r  <= membrane_nxt;
      current_r   <= current_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_b) begin
      spiked_r <= fired;
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the leaky integrate-and-fire neuron step block.
module tb;
  import lif_pkg::*;

  typedef struct {
    logic                     spiked;
    logic [CUR_W-1:0]         current;
    logic signed [VOLT_W-1:0] level;
  } neuron_step_t;

  class neuron_scoreboard;
    logic [FACT_W-1:0]        leak_rate;
    logic [CUR_W-1:0]         gain;
    logic signed [VOLT_W-1:0] threshold;
    logic signed [VOLT_W-1:0] rest_level;
    logic [FACT_W-1:0]        decay;
    logic signed [VOLT_W-1:0] membrane;
    logic [CUR_W-1:0]         current;
    neuron_step_t             expected_steps[$];
    int                       errors;

    function new();
      leak_rate  = RST_MEMBRANE_RATE;
      gain       = RST_DRIVE_GAIN;
      threshold  = RST_SPIKE_THRESHOLD;
      rest_level = RST_RESET_VOLTAGE;
      decay      = RST_CURRENT_DECAY;
      membrane   = '0;
      current    = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_MEMBRANE_RATE:   leak_rate  = value[FACT_W-1:0];
        CFG_DRIVE_GAIN:      gain       = value[CUR_W-1:0];
        CFG_SPIKE_THRESHOLD: threshold  = value;
        CFG_RESET_VOLTAGE:   rest_level = value;
        CFG_CURRENT_DECAY:   decay      = value[FACT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic signed [VOLT_W-1:0] x);
      longint one_q, rate_q, decay_q, vmax, vmin, imax;
      longint mem_l, gain_l, x_l, thr_l, rest_l, acc, v, cur;
      neuron_step_t outcome;
      one_q  = ONE_Q16;
      vmax   = V_MAX;
      vmin   = V_MIN;
      imax   = I_MAX;
      mem_l  = membrane;
      gain_l = gain;
      x_l    = x;
      thr_l  = threshold;
      rest_l = rest_level;
      rate_q = leak_rate;
      if (rate_q > one_q) rate_q = one_q;
      decay_q = decay;
      if (decay_q > one_q) decay_q = one_q;

      acc = mem_l * (one_q - rate_q) + gain_l * x_l;
      v = acc >>> FRAC_W;
      if (v > vmax) v = vmax;
      if (v < vmin) v = vmin;

      outcome.spiked = 1'b0;
      cur = current;
      if (v > thr_l) begin
        outcome.spiked = 1'b1;
        v = rest_l;
        cur = cur + one_q;
        if (cur > imax) cur = imax;
      end
      cur = (cur * decay_q) >> FRAC_W;
      if (cur > imax) cur = imax;

      membrane = v[VOLT_W-1:0];
      current  = cur[CUR_W-1:0];
      outcome.current = current;
      outcome.level   = membrane;
      expected_steps.push_back(outcome);
    endfunction

    function void check_step(logic spiked, logic [CUR_W-1:0] cur,
                             logic signed [VOLT_W-1:0] level);
      neuron_step_t want;
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t: result with no step pending: spiked %0b current %0d membrane %0d",
                 $time, spiked, cur, level);
      end else begin
        want = expected_steps.pop_front();
        if (spiked !== want.spiked) begin
          errors++;
          $display("%0t: spiked expected %0b actual %0b", $time, want.spiked, spiked);
        end
        if (cur !== want.current) begin
          errors++;
          $display("%0t: output_current expected %0d actual %0d", $time, want.current, cur);
        end
        if (level !== want.level) begin
          errors++;
          $display("%0t: membrane_level expected %0d actual %0d", $time, want.level, level);
        end
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count;
  bit   sender_gaps;
  bit   receiver_stalls;
  bit   choke_req;

  neuron_scoreboard board = new();

  lif_in_if  in_ch();
  lif_out_if out_ch();
  lif_cfg_if cfg_ch();

  lif_neuron_step dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    board.write_reg(idx, value);
  endtask

  task automatic program_neuron(input logic [FACT_W-1:0] rate, input logic [CUR_W-1:0] gain,
                                input logic signed [VOLT_W-1:0] thr,
                                input logic signed [VOLT_W-1:0] rest,
                                input logic [FACT_W-1:0] decay);
    cfg_write(CFG_MEMBRANE_RATE, CFG_DATA_W'(rate));
    cfg_write(CFG_DRIVE_GAIN, CFG_DATA_W'(gain));
    cfg_write(CFG_SPIKE_THRESHOLD, thr);
    cfg_write(CFG_RESET_VOLTAGE, rest);
    cfg_write(CFG_CURRENT_DECAY, CFG_DATA_W'(decay));
    for (int k = int'(CFG_CURRENT_DECAY) + 1; k < (1 << CFG_IDX_W); k++) begin
      cfg_write(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_tick(input logic signed [VOLT_W-1:0] x);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.input_sum <= x;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    board.note_tick(x);
  endtask

  task automatic drain_neuron();
    in_ch.valid <= 1'b0;
    while (board.expected_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [VOLT_W-1:0] random_tick();
    int near;
    if ($urandom_range(0, 3) == 0) return VOLT_W'($urandom);
    near = int'($urandom_range(0, 1 << 19)) - (1 << 18);
    return near[VOLT_W-1:0];
  endfunction

  task automatic program_random(input bit saturate);
    logic [FACT_W-1:0]        rate;
    logic [FACT_W-1:0]        decay;
    logic [CUR_W-1:0]         gain;
    logic signed [VOLT_W-1:0] thr;
    logic signed [VOLT_W-1:0] rest;
    case ($urandom_range(0, 3))
      0:       rate = '0;
      1:       rate = ONE_Q16;
      2:       rate = FACT_W'($urandom);
      default: rate = FACT_W'($urandom_range(0, 8192));
    endcase
    case ($urandom_range(0, 3))
      0:       gain = '0;
      1:       gain = '1;
      2:       gain = CUR_W'($urandom);
      default: gain = CUR_W'($urandom_range(0, 131072));
    endcase
    case ($urandom_range(0, 3))
      0:       decay = '0;
      1:       decay = ONE_Q16;
      2:       decay = FACT_W'($urandom);
      default: decay = FACT_W'($urandom_range(50000, 65535));
    endcase
    thr  = random_tick();
    rest = random_tick();
    if (saturate) begin
      // Firing on almost every tick with no decay drives the current into its ceiling.
      gain  = CUR_W'($urandom_range(0, 131072));
      thr   = V_MIN;
      decay = ONE_Q16 | FACT_W'($urandom_range(0, 65535));
    end
    program_neuron(rate, gain, thr, rest, decay);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      int hold;
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        board.check_step(out_ch.spiked, out_ch.output_current, out_ch.membrane_level);
      end
      if (choke_req) begin
        choke_req = 1'b0;
        hold = 64;
      end else if (hold == 0 && receiver_stalls && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 4);
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    choke_req       = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.input_sum <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_MEMBRANE_RATE;
    cfg_ch.data     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration, including a tick large enough to fire.
    send_tick('0);
    send_tick(VOLT_W'(20 << FRAC_W));
    send_tick(V_MAX);
    send_tick(V_MIN);
    send_tick('1);
    send_tick(VOLT_W'(1));
    drain_neuron();

    // Full leak and unit gain make the new voltage equal the input.
    program_neuron(ONE_Q16, CUR_W'(ONE_Q16), 24'sd1000, -24'sd5000, ONE_Q16);
    send_tick(24'sd1000);
    send_tick(24'sd1001);
    send_tick(24'sd999);
    send_tick('1);
    send_tick('0);
    send_tick(24'sd1001);
    drain_neuron();

    // Factors above one and maximum gain saturate the membrane both ways.
    program_neuron('1, '1, V_MAX, V_MIN, '1);
    send_tick(V_MAX);
    send_tick('0);
    send_tick(VOLT_W'(1));
    send_tick(V_MIN);
    drain_neuron();

    // No leak and no gain hold the voltage at the threshold, which must not fire.
    program_neuron('0, '0, V_MIN, V_MAX, '0);
    send_tick(V_MAX);
    send_tick(V_MIN);
    send_tick(random_tick());
    drain_neuron();

    for (int p = 0; p < 8; p++) begin
      sender_gaps     = (p != 7);
      receiver_stalls = (p != 7);
      program_random(p == 4);
      if (p == 2) choke_req = 1'b1;
      repeat ((p == 4) ? 160 : 90) send_tick(random_tick());
      drain_neuron();
    end

    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- lif_neuron_step.f -----
hdl/lif_pkg.sv
hdl/lif_if.sv
hdl/lif_cfg_regs.sv
hdl/lif_neuron_step.sv
sim/tb.sv
